// File: hw/rtl/otsu_pkg.sv
// ----------------------------------------------------------------------------
// otsu_pkg
// Shared widths, payload types, state and command encodings for the Otsu
// threshold finder.
// ----------------------------------------------------------------------------
package otsu_pkg;

  // Image size limit: up to 2^PIXEL_COUNT_BITS pixels per image
  localparam int PIXEL_COUNT_BITS = 20;
  localparam int NBINS            = 256;
  localparam int BIN_W            = 8;
  localparam int CNT_W            = PIXEL_COUNT_BITS + 1;  // pixel count, bin count
  localparam int SUM_W            = CNT_W + BIN_W;         // intensity sums
  localparam int PROD_W           = SUM_W + CNT_W;         // sb*N, wb*S, |D|
  localparam int SQ_W             = 2 * PROD_W;            // D^2
  localparam int DEN_W            = 2 * CNT_W;             // wb*wf
  localparam int MUL_A_W          = SQ_W;
  localparam int MUL_B_W          = PROD_W;
  localparam int MUL_P_W          = SQ_W + DEN_W;          // cross products

  typedef struct packed {
    logic [BIN_W-1:0] pixel;
    logic             last_pixel;
  } pix_in_t;

  typedef struct packed {
    logic [BIN_W-1:0] threshold;
    logic             split_found;
  } res_out_t;

  typedef enum logic [2:0] {
    MUL_X,
    MUL_Y,
    MUL_D2,
    MUL_DEN,
    MUL_LHS,
    MUL_RHS
  } mul_op_t;

  typedef enum logic [2:0] {
    ST_RUN,
    ST_RD,
    ST_ACC,
    ST_MSTART,
    ST_MWAIT,
    ST_CMP,
    ST_NEXT,
    ST_DONE
  } otsu_state_t;

  typedef struct packed {
    logic    hold_in;
    logic    scan_start;
    logic    rd;
    logic    acc;
    logic    mul_start;
    logic    mul_store;
    mul_op_t op;
    logic    cmp;
    logic    t_inc;
    logic    finish;
  } otsu_cmd_t;

  typedef struct packed {
    logic ingest_last;
    logic wb_zero;
    logic wf_zero;
    logic t_last;
    logic mul_done;
    logic res_busy;
  } otsu_sts_t;

endpackage

// File: hw/rtl/otsu_threshold_finder_unit.sv
// ----------------------------------------------------------------------------
// otsu_threshold_finder_unit
// Otsu threshold search over a stream of 8-bit gray pixels.
// ----------------------------------------------------------------------------
// Input channel px: one pixel per beat, last_pixel marks the end of an image.
// Pixels are taken one per cycle while the histogram is being built; the
// histogram update is a read-modify-write with forwarding between beats.
// Output channel res: one beat per image with the threshold and split_found.
// After the last pixel, px_stall stays high during the threshold scan. The
// scan reads bins 0..255 one at a time; each non-empty candidate runs six
// products through one shift-add multiplier (one bit per cycle, stopping at
// the top set bit of the multiplier operand). The scan stops early once the
// foreground is empty.
// The result waits in an output register; while res_stall holds it, the next
// image streams in normally and only its scan end waits for that register.
// Reset clears the histogram valid bits, totals, best candidate and channel
// state; the end of every scan clears the valid bits, totals and best candidate.
// Pixels past 2^20 in one image are dropped; last_pixel is still honored.
// ----------------------------------------------------------------------------
module otsu_threshold_finder_unit (
  input  logic                clk,
  input  logic                rst,
  input  logic                px_valid,
  output logic                px_stall,
  input  otsu_pkg::pix_in_t   px,
  output logic                res_valid,
  input  logic                res_stall,
  output otsu_pkg::res_out_t  res
);
  import otsu_pkg::*;

  otsu_cmd_t cmd;
  otsu_sts_t sts;

  assign px_stall = cmd.hold_in;

  otsu_ctrl u_ctrl (
    .clk (clk),
    .rst (rst),
    .sts (sts),
    .cmd (cmd)
  );

  otsu_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sts       (sts),
    .px_valid  (px_valid),
    .px        (px),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res)
  );

  // no new pixel while the final pixel of an image is still being committed
  a_last_holds_input: assert property (@(posedge clk) disable iff (rst)
    sts.ingest_last |-> px_stall)
    else $error("pixel accepted behind the last pixel");

  // a finished scan always presents a result beat
  a_finish_shows_result: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |=> res_valid)
    else $error("scan finished without a result");

  // products are captured only when the multiplier has finished
  a_store_after_done: assert property (@(posedge clk) disable iff (rst)
    cmd.mul_store |-> sts.mul_done)
    else $error("product captured before multiplier done");

endmodule

// File: hw/rtl/otsu_mul.sv
// ----------------------------------------------------------------------------
// otsu_mul
// Shift-and-add multiplier, one multiplier bit per cycle; finishes as soon
// as the remaining multiplier bits are all zero.
// ----------------------------------------------------------------------------
module otsu_mul (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [otsu_pkg::MUL_A_W-1:0]  a,
  input  logic [otsu_pkg::MUL_B_W-1:0]  b,
  output logic                          done,
  output logic [otsu_pkg::MUL_P_W-1:0]  p
);
  import otsu_pkg::*;

  logic               busy;
  logic [MUL_P_W-1:0] ar;
  logic [MUL_B_W-1:0] br;
  logic [MUL_P_W-1:0] acc;

  assign done = busy && (br == '0);
  assign p    = acc;

  // track the active operation
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
    end else if (done) begin
      busy <= 1'b0;
    end
  end

  // add one partial product per cycle
  always_ff @(posedge clk) begin
    if (start) begin
      ar  <= MUL_P_W'(a);
      br  <= b;
      acc <= '0;
    end else if (busy && (br != '0)) begin
      acc <= acc + (br[0] ? ar : '0);
      ar  <= ar << 1;
      br  <= br >> 1;
    end
  end

endmodule

// File: hw/rtl/otsu_dp.sv
// ----------------------------------------------------------------------------
// otsu_dp
// Datapath: histogram memory with read-modify-write forwarding, image totals,
// threshold scan accumulators, candidate compare and the result register.
// ----------------------------------------------------------------------------
module otsu_dp (
  input  logic                  clk,
  input  logic                  rst,
  input  otsu_pkg::otsu_cmd_t   cmd,
  output otsu_pkg::otsu_sts_t   sts,
  input  logic                  px_valid,
  input  otsu_pkg::pix_in_t     px,
  output logic                  res_valid,
  input  logic                  res_stall,
  output otsu_pkg::res_out_t    res
);
  import otsu_pkg::*;

  logic accept;

  // histogram storage
  logic [CNT_W-1:0] mem [NBINS];
  logic [NBINS-1:0] vld;
  logic [BIN_W-1:0] rd_addr;
  logic [CNT_W-1:0] rd_data;
  logic             rd_vld;

  // ingest stage
  logic             s1_valid;
  logic [BIN_W-1:0] s1_px;
  logic             s1_last;
  logic             wr_valid;
  logic [BIN_W-1:0] wr_px;
  logic [CNT_W-1:0] wr_cnt;
  logic             hist_we;
  logic [CNT_W-1:0] hist_cur;
  logic [CNT_W-1:0] hist_new;

  // image totals and scan state
  logic [CNT_W-1:0] total;
  logic [SUM_W-1:0] sum;
  logic [BIN_W-1:0] t;
  logic [CNT_W-1:0] wb;
  logic [SUM_W-1:0] sb;
  logic [CNT_W-1:0] bin_h;
  logic [CNT_W-1:0] wb_acc;
  logic [SUM_W-1:0] th_prod;
  logic [CNT_W-1:0] wf;

  // products and best candidate
  logic [PROD_W-1:0]  x;
  logic [PROD_W-1:0]  d;
  logic [SQ_W-1:0]    d2;
  logic [DEN_W-1:0]   den;
  logic [MUL_P_W-1:0] lhs;
  logic [MUL_P_W-1:0] rhs;
  logic [SQ_W-1:0]    best_num;
  logic [DEN_W-1:0]   best_den;
  logic [BIN_W-1:0]   best_t;

  logic [MUL_A_W-1:0] mul_a;
  logic [MUL_B_W-1:0] mul_b;
  logic [MUL_P_W-1:0] mul_p;
  logic               mul_done;

  assign accept = px_valid && !cmd.hold_in;

  // read for the scan or for the incoming pixel
  assign rd_addr = cmd.rd ? t : px.pixel;

  // drop pixels once the count reaches its limit
  assign hist_we  = s1_valid && !total[CNT_W-1];
  assign hist_cur = (wr_valid && (wr_px == s1_px)) ? wr_cnt :
                    (rd_vld ? rd_data : '0);
  assign hist_new = hist_cur + CNT_W'(1);

  // histogram memory, registered read
  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
    rd_vld  <= vld[rd_addr];
    if (hist_we) begin
      mem[s1_px] <= hist_new;
    end
  end

  // bin valid bits, cleared per image
  always_ff @(posedge clk) begin
    if (rst || cmd.finish) begin
      vld <= '0;
    end else if (hist_we) begin
      vld[s1_px] <= 1'b1;
    end
  end

  // ingest stage control and forwarding
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      wr_valid <= 1'b0;
    end else begin
      s1_valid <= accept;
      wr_valid <= hist_we;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_px   <= px.pixel;
      s1_last <= px.last_pixel;
    end
    if (hist_we) begin
      wr_px  <= s1_px;
      wr_cnt <= hist_new;
    end
  end

  // pixel count and intensity sum
  always_ff @(posedge clk) begin
    if (rst || cmd.finish) begin
      total <= '0;
      sum   <= '0;
    end else if (hist_we) begin
      total <= total + CNT_W'(1);
      sum   <= sum + SUM_W'(s1_px);
    end
  end

  // scan accumulation
  assign bin_h   = rd_vld ? rd_data : '0;
  assign wb_acc  = wb + bin_h;
  assign th_prod = SUM_W'(t) * SUM_W'(bin_h);
  assign wf      = total - wb;

  always_ff @(posedge clk) begin
    if (cmd.scan_start) begin
      t  <= '0;
      wb <= '0;
      sb <= '0;
    end else begin
      if (cmd.acc) begin
        wb <= wb_acc;
        sb <= sb + th_prod;
      end
      if (cmd.t_inc) begin
        t <= t + BIN_W'(1);
      end
    end
  end

  // select multiplier operands
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (cmd.op)
      MUL_X: begin
        mul_a = MUL_A_W'(sb);
        mul_b = MUL_B_W'(total);
      end
      MUL_Y: begin
        mul_a = MUL_A_W'(sum);
        mul_b = MUL_B_W'(wb);
      end
      MUL_D2: begin
        mul_a = MUL_A_W'(d);
        mul_b = d;
      end
      MUL_DEN: begin
        mul_a = MUL_A_W'(wb);
        mul_b = MUL_B_W'(wf);
      end
      MUL_LHS: begin
        mul_a = d2;
        mul_b = MUL_B_W'(best_den);
      end
      MUL_RHS: begin
        mul_a = best_num;
        mul_b = MUL_B_W'(den);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  otsu_mul u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .done  (mul_done),
    .p     (mul_p)
  );

  // capture products; take |sb*N - wb*S| with the second one
  always_ff @(posedge clk) begin
    if (cmd.mul_store) begin
      case (cmd.op)
        MUL_X:   x <= mul_p[PROD_W-1:0];
        MUL_Y: begin
          if (x >= mul_p[PROD_W-1:0]) begin
            d <= x - mul_p[PROD_W-1:0];
          end else begin
            d <= mul_p[PROD_W-1:0] - x;
          end
        end
        MUL_D2:  d2  <= mul_p[SQ_W-1:0];
        MUL_DEN: den <= mul_p[DEN_W-1:0];
        MUL_LHS: lhs <= mul_p;
        MUL_RHS: rhs <= mul_p;
        default: ;
      endcase
    end
  end

  // keep the first strictly larger variance
  always_ff @(posedge clk) begin
    if (rst || cmd.finish) begin
      best_num <= '0;
      best_den <= DEN_W'(1);
      best_t   <= '0;
    end else if (cmd.cmp && (lhs > rhs)) begin
      best_num <= d2;
      best_den <= den;
      best_t   <= t;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (cmd.finish) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      res.threshold   <= best_t;
      res.split_found <= |best_num;
    end
  end

  // status to the controller
  always_comb begin
    sts.ingest_last = s1_valid && s1_last;
    sts.wb_zero     = (wb_acc == '0);
    sts.wf_zero     = (wb_acc == total);
    sts.t_last      = (t == BIN_W'(NBINS - 1));
    sts.mul_done    = mul_done;
    sts.res_busy    = res_valid && res_stall;
  end

endmodule

// File: hw/rtl/otsu_ctrl.sv
// ----------------------------------------------------------------------------
// otsu_ctrl
// Sequencer: runs the pixel intake, then steps the threshold scan through
// bin reads and the product chain for each candidate.
// ----------------------------------------------------------------------------
module otsu_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  otsu_pkg::otsu_sts_t   sts,
  output otsu_pkg::otsu_cmd_t   cmd
);
  import otsu_pkg::*;

  otsu_state_t state;
  otsu_state_t state_next;
  mul_op_t     op;
  mul_op_t     op_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_RUN;
      op    <= MUL_X;
    end else begin
      state <= state_next;
      op    <= op_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    op_next    = op;
    unique case (state)
      ST_RUN: begin
        if (sts.ingest_last) state_next = ST_RD;
      end
      ST_RD: state_next = ST_ACC;
      ST_ACC: begin
        if (sts.wb_zero) begin
          state_next = ST_NEXT;
        end else if (sts.wf_zero) begin
          state_next = ST_DONE;
        end else begin
          state_next = ST_MSTART;
          op_next    = MUL_X;
        end
      end
      ST_MSTART: state_next = ST_MWAIT;
      ST_MWAIT: begin
        if (sts.mul_done) begin
          state_next = ST_MSTART;
          unique case (op)
            MUL_X:   op_next = MUL_Y;
            MUL_Y:   op_next = MUL_D2;
            MUL_D2:  op_next = MUL_DEN;
            MUL_DEN: op_next = MUL_LHS;
            MUL_LHS: op_next = MUL_RHS;
            MUL_RHS: state_next = ST_CMP;
            default: op_next = MUL_X;
          endcase
        end
      end
      ST_CMP: state_next = ST_NEXT;
      ST_NEXT: begin
        state_next = sts.t_last ? ST_DONE : ST_RD;
      end
      ST_DONE: begin
        if (!sts.res_busy) state_next = ST_RUN;
      end
      default: state_next = ST_RUN;
    endcase
  end

  // commands
  always_comb begin
    cmd            = '0;
    cmd.op         = op;
    cmd.hold_in    = (state != ST_RUN) || sts.ingest_last;
    unique case (state)
      ST_RUN:    cmd.scan_start = sts.ingest_last;
      ST_RD:     cmd.rd         = 1'b1;
      ST_ACC:    cmd.acc        = 1'b1;
      ST_MSTART: cmd.mul_start  = 1'b1;
      ST_MWAIT:  cmd.mul_store  = sts.mul_done;
      ST_CMP:    cmd.cmp        = 1'b1;
      ST_NEXT:   cmd.t_inc      = !sts.t_last;
      ST_DONE:   cmd.finish     = !sts.res_busy;
      default:   cmd.rd         = 1'b0;
    endcase
  end

endmodule

// File: tb/sv/otsu_threshold_finder_unit_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// otsu_threshold_finder_unit_test
// Streams gray images through the Otsu threshold finder and checks every
// threshold beat against an exact in-bench histogram and variance search.
// ----------------------------------------------------------------------------
module otsu_threshold_finder_unit_test;
  import otsu_pkg::*;

  localparam longint PIXEL_LIMIT = longint'(1) << PIXEL_COUNT_BITS;
  localparam longint CYCLE_LIMIT = 8000000;
  localparam int     HOLD_CYCLES = 40000;

  logic     clk;
  logic     rst;
  logic     px_valid;
  logic     px_stall;
  pix_in_t  px;
  logic     res_valid;
  logic     res_stall;
  res_out_t res;

  // pending pixel beats and expected threshold beats
  pix_in_t  pixel_queue[$];
  res_out_t threshold_queue[$];

  // image state of the predictor
  longint   bin_count[NBINS];
  longint   image_pixels;
  longint   image_intensity;

  int       errors;
  longint   cycles;
  bit       quiet;
  bit       hold_req;
  bit       hold_seen;
  int       hold_left;
  int       tx_gap;
  int       rx_gap;

  otsu_threshold_finder_unit u_dut (
    .clk       (clk),
    .rst       (rst),
    .px_valid  (px_valid),
    .px_stall  (px_stall),
    .px        (px),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res)
  );

  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  // Clear the histogram and totals of the predictor.
  function automatic void clear_image();
    for (int i = 0; i < NBINS; i++) bin_count[i] = 0;
    image_pixels    = 0;
    image_intensity = 0;
  endfunction

  // Scan all thresholds exactly and return the chosen split.
  function automatic res_out_t search_threshold();
    bit [255:0] n_big;
    bit [255:0] s_big;
    bit [255:0] lhs;
    bit [255:0] rhs;
    bit [255:0] x;
    bit [255:0] y;
    bit [255:0] d;
    bit [255:0] d2;
    bit [255:0] best_num;
    bit [255:0] best_den;
    longint     wb;
    longint     wf;
    longint     sb;
    res_out_t   r;
    n_big    = image_pixels;
    s_big    = image_intensity;
    best_num = 0;
    best_den = 1;
    wb       = 0;
    sb       = 0;
    r.threshold = '0;
    for (int t = 0; t < NBINS; t++) begin
      wb += bin_count[t];
      if (wb == 0) continue;
      wf = image_pixels - wb;
      if (wf == 0) break;
      sb += t * bin_count[t];
      x  = 256'(sb) * n_big;
      y  = 256'(wb) * s_big;
      d  = (x >= y) ? x - y : y - x;
      d2 = d * d;
      lhs = d2 * best_den;
      rhs = best_num * (256'(wb) * 256'(wf));
      if (lhs > rhs) begin
        best_num    = d2;
        best_den    = 256'(wb) * 256'(wf);
        r.threshold = t[7:0];
      end
    end
    r.split_found = (best_num != 0);
    return r;
  endfunction

  // Take in one accepted pixel beat; on the last pixel queue the threshold.
  function automatic void take_pixel(pix_in_t p);
    if (image_pixels < PIXEL_LIMIT) begin
      bin_count[p.pixel] += 1;
      image_pixels       += 1;
      image_intensity    += p.pixel;
    end
    if (p.last_pixel) begin
      threshold_queue.push_back(search_threshold());
      clear_image();
    end
  endfunction

  // Pixel driver: predict on acceptance, then offer the next beat or idle.
  always @(posedge clk) begin
    if (rst) begin
      px_valid <= 1'b0;
      px       <= '0;
      tx_gap   <= 0;
    end else begin
      if (px_valid && !px_stall) take_pixel(px);
      if (!px_valid || !px_stall) begin
        if (tx_gap > 0) begin
          tx_gap   <= tx_gap - 1;
          px_valid <= 1'b0;
        end else if (!quiet && $urandom_range(0, 9) == 0) begin
          tx_gap   <= int'($urandom_range(0, 13));
          px_valid <= 1'b0;
        end else if (pixel_queue.size() > 0) begin
          px       <= pixel_queue.pop_front();
          px_valid <= 1'b1;
        end else begin
          px_valid <= 1'b0;
        end
      end
    end
  end

  // Result receiver: random stall bursts plus one long hold-off.
  always @(posedge clk) begin
    if (rst) begin
      res_stall <= 1'b0;
      rx_gap    <= 0;
      hold_left <= 0;
      hold_seen <= 1'b0;
    end else if (hold_req && !hold_seen) begin
      hold_seen <= 1'b1;
      hold_left <= HOLD_CYCLES;
      res_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      res_stall <= (hold_left > 1);
    end else if (rx_gap > 0) begin
      rx_gap    <= rx_gap - 1;
      res_stall <= (rx_gap > 1);
    end else if (!quiet && $urandom_range(0, 7) == 0) begin
      rx_gap    <= int'($urandom_range(0, 13));
      res_stall <= 1'b1;
    end else begin
      res_stall <= 1'b0;
    end
  end

  // Compare each accepted threshold beat with the oldest expectation.
  always @(posedge clk) begin
    if (!rst && res_valid && !res_stall) begin
      if (threshold_queue.size() == 0) begin
        errors++;
        $display("%0t: unexpected beat, expected none, actual thr=%0d split=%0b",
                 $time, res.threshold, res.split_found);
      end else begin
        res_out_t e;
        e = threshold_queue.pop_front();
        if (res.threshold !== e.threshold) begin
          errors++;
          $display("%0t: threshold mismatch, expected %0d, actual %0d",
                   $time, e.threshold, res.threshold);
        end
        if (res.split_found !== e.split_found) begin
          errors++;
          $display("%0t: split_found mismatch, expected %0b, actual %0b",
                   $time, e.split_found, res.split_found);
        end
      end
    end
  end

  // Abort a hung run.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  task automatic push_pixel(input logic [7:0] value, input logic last);
    pix_in_t p;
    p.pixel      = value;
    p.last_pixel = last;
    pixel_queue.push_back(p);
  endtask

  // Queue one image of random length with clustered or scattered pixels.
  task automatic push_image(input int len);
    int     style;
    logic [7:0] center;
    logic [7:0] value;
    style  = int'($urandom_range(0, 3));
    center = 8'($urandom_range(0, 255));
    for (int i = 0; i < len; i++) begin
      case (style)
        0: value = 8'($urandom_range(0, 255));
        1: value = $urandom_range(0, 1) ? center : ~center;
        2: value = center;
        default: value = center ^ 8'($urandom_range(0, 7));
      endcase
      push_pixel(value, i == len - 1);
    end
  endtask

  // Hold until every queued beat is sent and every threshold has arrived.
  task automatic drain();
    while (pixel_queue.size() > 0 || threshold_queue.size() > 0 || px_valid)
      @(posedge clk);
  endtask

  initial begin
    int sent;
    int len;
    errors    = 0;
    cycles    = 0;
    quiet     = 1'b0;
    hold_req  = 1'b0;
    rst       = 1'b1;
    px_valid  = 1'b0;
    px        = '0;
    res_stall = 1'b0;
    clear_image();
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // directed: single pixels, extremes, equal pixels, two-class splits
    push_pixel(8'd0, 1'b1);
    push_pixel(8'd255, 1'b1);
    push_pixel(8'd0, 1'b0);
    push_pixel(8'd255, 1'b1);
    push_pixel(8'd7, 1'b0);
    push_pixel(8'd7, 1'b0);
    push_pixel(8'd7, 1'b1);
    push_pixel(8'h55, 1'b0);
    push_pixel(8'hAA, 1'b0);
    push_pixel(8'h80, 1'b0);
    push_pixel(8'h01, 1'b1);
    push_pixel(8'd10, 1'b0);
    push_pixel(8'd10, 1'b0);
    push_pixel(8'd200, 1'b0);
    push_pixel(8'd200, 1'b0);
    push_pixel(8'd100, 1'b1);
    push_pixel(8'd255, 1'b0);
    push_pixel(8'd254, 1'b0);
    push_pixel(8'd0, 1'b1);
    drain();

    // long receiver hold-off while several images stream in
    hold_req = 1'b1;
    for (int i = 0; i < 6; i++) push_image(int'($urandom_range(2, 12)));
    drain();

    // random images; the last stretch runs without idling
    sent = 0;
    while (sent < 490) begin
      len = ($urandom_range(0, 9) == 0) ? int'($urandom_range(30, 60))
                                        : int'($urandom_range(1, 16));
      if (sent > 400) quiet = 1'b1;
      push_image(len);
      sent += len;
    end
    drain();
    repeat (300) @(posedge clk);

    if (errors == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule
